FILE: src/dss_pkg.sv
// Shared types and constants for the disk seek scheduler.
// Used by dss_front, dss_back, dss_outq and disk_seek_scheduler.
package dss_pkg;

  localparam int MAX_REQUESTS = 32;
  localparam int CYL_W        = 16;
  localparam int IDX_W        = $clog2(MAX_REQUESTS);
  localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
  localparam int MOVE_W       = 22;
  localparam logic [MOVE_W-1:0] MOVE_MAX = {MOVE_W{1'b1}};
  localparam int SIZE_W       = 17;
  localparam int CFG_IDX_W    = 2;
  localparam int OQ_DEPTH     = 4;
  localparam int OQ_PTR_W     = $clog2(OQ_DEPTH);

  // policy codes
  localparam logic [2:0] MODE_FCFS       = 3'd0;
  localparam logic [2:0] MODE_SSTF       = 3'd1;
  localparam logic [2:0] MODE_SCAN_DOWN  = 3'd2;
  localparam logic [2:0] MODE_SCAN_UP    = 3'd3;
  localparam logic [2:0] MODE_CSCAN_DOWN = 3'd4;
  localparam logic [2:0] MODE_CSCAN_UP   = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISK   = 2'd2;

  // sweep stages of the scan policies
  localparam logic [1:0] STG_FIRST  = 2'd0;
  localparam logic [1:0] STG_BND1   = 2'd1;
  localparam logic [1:0] STG_BND2   = 2'd2;
  localparam logic [1:0] STG_SECOND = 2'd3;

  typedef struct packed {
    logic [CYL_W-1:0] request_cylinder;
    logic             last_request;
  } req_t;

  typedef struct packed {
    logic [CYL_W-1:0]  position;
    logic              boundary_visit;
    logic [MOVE_W-1:0] movement_so_far;
    logic              last_result;
  } res_t;

  typedef struct packed {
    logic [2:0]        policy_mode;
    logic [CYL_W-1:0]  start_position;
    logic [SIZE_W-1:0] num_cyl;
  } cfg_t;

  // batch token from front to back
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] count;
  } batch_t;

  // back to front control
  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] rd_addr;
  } back_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_NEXT, ST_FETCH, ST_FWAIT, ST_SCAN, ST_EMIT, ST_DONE
  } back_state_t;

endpackage

FILE: src/dss_front.sv
// Front end: accepts request words, stores them, hands a batch token to the back.
// Depends on dss_pkg.
module dss_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dss_pkg::req_t       in_data,
  input  dss_pkg::back_ctl_t  ctl,
  output dss_pkg::batch_t     batch,
  output logic [dss_pkg::CYL_W-1:0] rd_data
);
  import dss_pkg::*;

  logic [CYL_W-1:0] store [MAX_REQUESTS];
  logic [CNT_W-1:0] count;
  logic             busy;
  logic             accept;

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  assign batch.valid = busy;
  assign batch.count = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      busy  <= 1'b0;
    end else if (ctl.done) begin
      count <= '0;
      busy  <= 1'b0;
    end else if (accept) begin
      // drop requests once the store is full
      if (count < CNT_W'(MAX_REQUESTS)) begin
        count <= count + CNT_W'(1);
      end
      if (in_data.last_request) begin
        busy <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && count < CNT_W'(MAX_REQUESTS)) begin
      store[count[IDX_W-1:0]] <= in_data.request_cylinder;
    end
    rd_data <= store[ctl.rd_addr];
  end

endmodule

FILE: src/dss_outq.sv
// Output queue: small FIFO of result words between the back end and the port.
// Depends on dss_pkg.
module dss_outq (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dss_pkg::res_t push_data,
  output logic          full,
  output logic          out_valid,
  input  logic          out_ready,
  output dss_pkg::res_t out_data
);
  import dss_pkg::*;

  res_t                 entry [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]  wr_ptr;
  logic [OQ_PTR_W-1:0]  rd_ptr;
  logic [OQ_PTR_W:0]    fill;
  logic                 pop;

  assign full      = fill == (OQ_PTR_W+1)'(OQ_DEPTH);
  assign out_valid = fill != '0;
  assign out_data  = entry[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + OQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + OQ_PTR_W'(1);
      end
      case ({push && !full, pop})
        2'b10:   fill <= fill + (OQ_PTR_W+1)'(1);
        2'b01:   fill <= fill - (OQ_PTR_W+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entry[wr_ptr] <= push_data;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && full)) else $error("push into full output queue");
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= (OQ_PTR_W+1)'(OQ_DEPTH)) else $error("output queue fill out of range");
  a_pop_moves: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> fill == $past(fill) - (OQ_PTR_W+1)'(1))
    else $error("pop did not drop fill");

endmodule

FILE: src/dss_back.sv
// Back end: selects each next head position for the batch and pushes result words.
// Depends on dss_pkg; reads the request store through the front end's read port.
module dss_back (
  input  logic                      clk,
  input  logic                      rst,
  input  dss_pkg::cfg_t             cfg,
  input  dss_pkg::batch_t           batch,
  input  logic [dss_pkg::CYL_W-1:0] rd_data,
  output dss_pkg::back_ctl_t        ctl,
  output logic                      push,
  output dss_pkg::res_t             push_data,
  input  logic                      q_full
);
  import dss_pkg::*;

  back_state_t state, state_next;

  logic [2:0]          mode;
  logic [CYL_W-1:0]    head0;
  logic [CYL_W-1:0]    top_cyl;
  logic [CNT_W-1:0]    n;
  logic [CYL_W-1:0]    head;
  logic [MOVE_W-1:0]   total;
  logic [1:0]          stage;
  logic [MAX_REQUESTS-1:0] served;
  logic [CNT_W-1:0]    served_cnt;
  logic [CNT_W-1:0]    scan_idx;
  logic                rd_pend;
  logic [IDX_W-1:0]    rd_idx;
  logic                found;
  logic [CYL_W-1:0]    best_v;
  logic [IDX_W-1:0]    best_i;
  logic [CYL_W-1:0]    best_d;
  logic [CYL_W-1:0]    pos;
  logic                bnd;
  logic                lastf;

  logic fcfs_like, sstf, cscan, asc, cls_upper, eligible, better;
  logic scan_end, all_served;
  logic [CYL_W-1:0]  cand_d, move_d, bnd_pos;
  logic [MOVE_W:0]   sum;
  logic [MOVE_W-1:0] total_next;
  logic [SIZE_W-1:0] size_m1;

  assign sstf      = mode == MODE_SSTF;
  assign cscan     = mode == MODE_CSCAN_DOWN || mode == MODE_CSCAN_UP;
  assign fcfs_like = !(mode == MODE_SSTF || mode == MODE_SCAN_DOWN ||
                       mode == MODE_SCAN_UP || cscan);
  assign all_served = served_cnt == n;
  assign scan_end   = scan_idx == n && !rd_pend;

  // upward policies start on the upper side
  assign cls_upper = (stage == STG_FIRST) ? mode[0] : !mode[0];
  assign asc       = (stage == STG_FIRST) ? mode[0] :
                     (mode == MODE_SCAN_DOWN || mode == MODE_CSCAN_UP);

  assign cand_d = (rd_data > head) ? rd_data - head : head - rd_data;
  assign eligible = !served[rd_idx] &&
                    (sstf || (cls_upper ? rd_data >= head0 : rd_data < head0));
  always_comb begin
    if (!found) begin
      better = 1'b1;
    end else if (sstf) begin
      better = cand_d < best_d;
    end else if (asc) begin
      better = rd_data < best_v;
    end else begin
      better = rd_data > best_v;
    end
  end

  assign move_d     = (pos > head) ? pos - head : head - pos;
  assign sum        = {1'b0, total} + (MOVE_W+1)'(move_d);
  assign total_next = (sum > {1'b0, MOVE_MAX}) ? MOVE_MAX : sum[MOVE_W-1:0];
  assign bnd_pos    = (stage == STG_BND1) ? (mode[0] ? top_cyl : '0)
                                          : (mode[0] ? '0 : top_cyl);
  assign size_m1    = cfg.num_cyl - SIZE_W'(1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (batch.valid) state_next = ST_NEXT;
      end
      ST_NEXT: begin
        if (fcfs_like) begin
          state_next = all_served ? ST_DONE : ST_FETCH;
        end else if (sstf) begin
          state_next = all_served ? ST_DONE : ST_SCAN;
        end else begin
          case (stage)
            STG_FIRST:  state_next = all_served ? ST_NEXT : ST_SCAN;
            STG_SECOND: state_next = all_served ? ST_DONE : ST_SCAN;
            default:    state_next = ST_EMIT;
          endcase
        end
      end
      ST_FETCH: state_next = ST_FWAIT;
      ST_FWAIT: state_next = ST_EMIT;
      ST_SCAN: begin
        if (scan_end) state_next = found ? ST_EMIT : ST_NEXT;
      end
      ST_EMIT: begin
        if (!q_full) state_next = ST_NEXT;
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl.done    = state == ST_DONE;
    ctl.rd_addr = (state == ST_FETCH) ? served_cnt[IDX_W-1:0] : scan_idx[IDX_W-1:0];
    push        = state == ST_EMIT && !q_full;
    push_data.position        = pos;
    push_data.boundary_visit  = bnd;
    push_data.movement_so_far = total_next;
    push_data.last_result     = lastf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      served     <= '0;
      served_cnt <= '0;
      stage      <= STG_FIRST;
      rd_pend    <= 1'b0;
      found      <= 1'b0;
      scan_idx   <= '0;
      head       <= '0;
      total      <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (batch.valid) begin
            mode       <= cfg.policy_mode;
            head0      <= cfg.start_position;
            head       <= cfg.start_position;
            n          <= batch.count;
            total      <= '0;
            served     <= '0;
            served_cnt <= '0;
            stage      <= STG_FIRST;
            if (cfg.num_cyl == '0) begin
              top_cyl <= '0;
            end else if (size_m1 > SIZE_W'({CYL_W{1'b1}})) begin
              top_cyl <= {CYL_W{1'b1}};
            end else begin
              top_cyl <= size_m1[CYL_W-1:0];
            end
          end
        end
        ST_NEXT: begin
          scan_idx <= '0;
          rd_pend  <= 1'b0;
          found    <= 1'b0;
          if (!fcfs_like && !sstf) begin
            if (stage == STG_FIRST && all_served) begin
              stage <= STG_BND1;
            end else if (stage == STG_BND1 || stage == STG_BND2) begin
              pos   <= bnd_pos;
              bnd   <= 1'b1;
              lastf <= all_served && (stage == STG_BND2 || !cscan);
            end
          end
        end
        ST_FWAIT: begin
          pos   <= rd_data;
          bnd   <= 1'b0;
          lastf <= served_cnt + CNT_W'(1) == n;
        end
        ST_SCAN: begin
          // issue one read a cycle, judge the word from the previous one
          if (scan_idx != n) begin
            scan_idx <= scan_idx + CNT_W'(1);
            rd_idx   <= scan_idx[IDX_W-1:0];
          end
          rd_pend <= scan_idx != n;
          if (rd_pend && eligible && better) begin
            found  <= 1'b1;
            best_v <= rd_data;
            best_i <= rd_idx;
            best_d <= cand_d;
          end
          if (scan_end) begin
            if (found) begin
              pos   <= best_v;
              bnd   <= 1'b0;
              lastf <= served_cnt + CNT_W'(1) == n && (sstf || stage == STG_SECOND);
            end else begin
              stage <= STG_BND1;
            end
          end
        end
        ST_EMIT: begin
          if (!q_full) begin
            head  <= pos;
            total <= total_next;
            if (bnd) begin
              stage <= (stage == STG_BND1 && cscan) ? STG_BND2 : STG_SECOND;
            end else begin
              served_cnt <= served_cnt + CNT_W'(1);
              if (!fcfs_like) served[best_i] <= 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_cnt_le_n: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> served_cnt <= n) else $error("served count beyond batch");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE |=> state == ST_IDLE) else $error("done not followed by idle");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    push && push_data.last_result |=> state == ST_NEXT && (all_served || bnd))
    else $error("last result pushed with work left");

endmodule

FILE: src/disk_seek_scheduler.sv
// Disk seek scheduler top level: configuration registers and the three parts.
// Depends on dss_pkg, dss_front, dss_back, dss_outq.
//
// Usage: write policy_mode (index 0), start_position (1) and num_cyl (2)
// on the cfg channel while idle; cfg_ready is always high. Send request words
// on the in channel, the final one of a batch with last_request set. No result
// comes for a plain request; the closing word starts the scheduler, and in_ready
// stays low until every result of the batch has been produced.
// Results leave on the out channel in service order through a four-entry
// queue. FCFS fetches the requests from the store in arrival order; SSTF,
// SCAN and C-SCAN pick each result by sweeping all n stored requests of the
// batch through the single store read port, one entry per cycle. A boundary
// word follows a sweep that finds no candidate and the first sweep once it
// has served every request, and C-SCAN gives a second one for the other end.
// When the receiver stalls, the queue fills and the scheduler holds its word.
// Reset clears the queue, the batch count, the served marks and the config
// registers (policy FCFS, start 0, 65536 cylinders).
module disk_seek_scheduler (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  dss_pkg::req_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output dss_pkg::res_t                 out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dss_pkg::SIZE_W-1:0]    cfg_data
);
  import dss_pkg::*;

  cfg_t             cfg;
  batch_t           batch;
  back_ctl_t        ctl;
  logic [CYL_W-1:0] rd_data;
  logic             push;
  res_t             push_data;
  logic             q_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.policy_mode    <= MODE_FCFS;
      cfg.start_position <= '0;
      cfg.num_cyl        <= SIZE_W'(65536);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_POLICY: cfg.policy_mode    <= cfg_data[2:0];
        CFG_START:  cfg.start_position <= cfg_data[CYL_W-1:0];
        CFG_DISK:   cfg.num_cyl        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  dss_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .ctl      (ctl),
    .batch    (batch),
    .rd_data  (rd_data)
  );

  dss_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .batch     (batch),
    .rd_data   (rd_data),
    .ctl       (ctl),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  dss_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
